// ===== rtl/core/ansi_sgr_line_to_cells_macros.svh =====
// Assertion helpers used by the RTL top
`ifndef ANSI_SGR_LINE_TO_CELLS_MACROS_SVH
`define ANSI_SGR_LINE_TO_CELLS_MACROS_SVH

// Same-cycle implication
`define ASGR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication
`define ASGR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/core/asgr_pkg.sv =====
package asgr_pkg;

   localparam int MAX_COLS = 1024;

   localparam int CP_W    = 21;
   localparam int GW_W    = 2;
   localparam int ROW_W   = 8;
   localparam int LW_W    = 11;
   localparam int RIU_W   = 9;
   localparam int CCOL_W  = 10;
   localparam int STYLE_W = 22;

   localparam logic CSR_LINE_WIDTH  = 1'b0;
   localparam logic CSR_ROWS_IN_USE = 1'b1;

   typedef struct packed {
      logic [LW_W-1:0]  line_width;
      logic [RIU_W-1:0] rows_in_use;
   } cfg_type;

   typedef struct packed {
      logic             line_end;
      logic [ROW_W-1:0] row;
      logic [GW_W-1:0]  glyph_width;
      logic [CP_W-1:0]  codepoint;
   } item_type;

   typedef struct packed {
      logic               line_done;
      logic               row_error;
      logic               wide;
      logic [STYLE_W-1:0] cell_style;
      logic [CP_W-1:0]    cell_char;
      logic [CCOL_W-1:0]  cell_column;
      logic [ROW_W-1:0]   cell_row;
      logic               write_cell;
   } result_type;

   function automatic logic [LW_W-1:0] clamp_width(input logic [LW_W-1:0] lw);
      logic [LW_W-1:0] lim;
      lim = LW_W'(MAX_COLS);
      return (lw > lim) ? lim : lw;
   endfunction

endpackage

// ===== rtl/core/asgr_csr.sv =====
module asgr_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [10:0]            csr_data,
   output asgr_pkg::cfg_type      cfg
);

   logic [asgr_pkg::LW_W-1:0]  line_width_ff;
   logic [asgr_pkg::RIU_W-1:0] rows_in_use_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff  <= asgr_pkg::LW_W'(80);
         rows_in_use_ff <= asgr_pkg::RIU_W'(24);
      end else if (csr_valid) begin
         case (csr_index)
            asgr_pkg::CSR_LINE_WIDTH:  line_width_ff  <= csr_data[asgr_pkg::LW_W-1:0];
            asgr_pkg::CSR_ROWS_IN_USE: rows_in_use_ff <= csr_data[asgr_pkg::RIU_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.line_width  = line_width_ff;
   assign cfg.rows_in_use = rows_in_use_ff;

endmodule

// ===== rtl/core/asgr_engine.sv =====
module asgr_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  asgr_pkg::cfg_type      cfg,
   input  asgr_pkg::item_type     item,
   output asgr_pkg::result_type   result
);

   typedef enum logic [1:0] {
      MODE_TEXT,
      MODE_ESC,
      MODE_CSI
   } mode_type;

   localparam logic [2:0] STEP_PLAIN  = 3'd0;
   localparam logic [2:0] STEP_FG_SEL = 3'd1;
   localparam logic [2:0] STEP_FG_IDX = 3'd2;
   localparam logic [2:0] STEP_BG_SEL = 3'd3;
   localparam logic [2:0] STEP_BG_IDX = 3'd4;

   localparam logic [20:0] CP_ESC   = 21'h1B;
   localparam logic [20:0] CP_LBRK  = 21'h5B;
   localparam logic [20:0] CP_M     = 21'h6D;
   localparam logic [20:0] CP_ZERO  = 21'h30;
   localparam logic [20:0] CP_NINE  = 21'h39;
   localparam logic [20:0] CP_SPACE = 21'h20;
   localparam logic [20:0] CP_DEL   = 21'h7F;
   localparam logic [20:0] CP_HIGH  = 21'h80;

   localparam logic [15:0] SGR_RESET  = 16'd0;
   localparam logic [15:0] SGR_BOLD   = 16'd1;
   localparam logic [15:0] SGR_DIM    = 16'd2;
   localparam logic [15:0] SGR_ITALIC = 16'd3;
   localparam logic [15:0] SGR_INV    = 16'd7;
   localparam logic [15:0] SGR_FG_EXT = 16'd38;
   localparam logic [15:0] SGR_BG_EXT = 16'd48;
   localparam logic [15:0] SGR_INDEX  = 16'd5;

   mode_type   mode_ff, mode_in;
   logic [15:0] value_ff, value_in;
   logic        present_ff, present_in;
   logic [2:0]  step_ff, step_in;
   logic [8:0]  fg_ff, fg_in;
   logic [8:0]  bg_ff, bg_in;
   logic [3:0]  flags_ff, flags_in;
   logic [10:0] column_ff, column_in;

   logic        rerr;
   logic        is_digit;
   logic        text;
   logic [19:0] acc;
   logic [15:0] n;
   logic [8:0]  n_color;
   logic [1:0]  cw;
   logic [10:0] w;
   logic        wr;
   logic        wd;

   always_comb begin
      rerr     = {1'b0, item.row} >= cfg.rows_in_use;
      is_digit = (item.codepoint >= CP_ZERO) && (item.codepoint <= CP_NINE);
      n        = present_ff ? value_ff : 16'd0;
      n_color  = n[8:0] + 9'd1;
      acc      = present_ff ? (20'(value_ff) * 20'd10 + 20'(item.codepoint[3:0]))
                            : 20'(item.codepoint[3:0]);
      w        = asgr_pkg::clamp_width(cfg.line_width);

      mode_in    = mode_ff;
      value_in   = value_ff;
      present_in = present_ff;
      step_in    = step_ff;
      fg_in      = fg_ff;
      bg_in      = bg_ff;
      flags_in   = flags_ff;
      column_in  = column_ff;
      text       = 1'b0;
      wr         = 1'b0;
      wd         = 1'b0;

      if (!rerr) begin
         case (mode_ff)
            MODE_CSI: begin
               if (is_digit) begin
                  value_in   = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];
                  present_in = 1'b1;
               end else begin
                  if (step_ff == STEP_FG_IDX) begin
                     fg_in   = n_color;
                     step_in = STEP_PLAIN;
                  end else if (step_ff == STEP_BG_IDX) begin
                     bg_in   = n_color;
                     step_in = STEP_PLAIN;
                  end else if (step_ff == STEP_FG_SEL && n == SGR_INDEX) begin
                     step_in = STEP_FG_IDX;
                  end else if (step_ff == STEP_BG_SEL && n == SGR_INDEX) begin
                     step_in = STEP_BG_IDX;
                  end else begin
                     step_in = STEP_PLAIN;
                     case (n)
                        SGR_RESET: begin
                           fg_in    = 9'd0;
                           bg_in    = 9'd0;
                           flags_in = 4'd0;
                        end
                        SGR_BOLD:   flags_in = flags_ff | 4'b0001;
                        SGR_DIM:    flags_in = flags_ff | 4'b0010;
                        SGR_ITALIC: flags_in = flags_ff | 4'b0100;
                        SGR_INV:    flags_in = flags_ff | 4'b1000;
                        SGR_FG_EXT: step_in  = STEP_FG_SEL;
                        SGR_BG_EXT: step_in  = STEP_BG_SEL;
                        default: ;
                     endcase
                  end
                  value_in   = 16'd0;
                  present_in = 1'b0;
                  if (item.codepoint == CP_M) begin
                     mode_in = MODE_TEXT;
                     step_in = STEP_PLAIN;
                  end
               end
            end
            MODE_ESC: begin
               if (item.codepoint == CP_LBRK) begin
                  mode_in    = MODE_CSI;
                  value_in   = 16'd0;
                  present_in = 1'b0;
                  step_in    = STEP_PLAIN;
               end else if (item.codepoint != CP_ESC) begin
                  mode_in = MODE_TEXT;
                  text    = 1'b1;
               end
            end
            default: begin
               if (item.codepoint == CP_ESC) begin
                  mode_in = MODE_ESC;
               end else begin
                  mode_in = MODE_TEXT;
                  text    = 1'b1;
               end
            end
         endcase
      end

      if (item.codepoint < CP_HIGH) begin
         cw = (item.codepoint >= CP_SPACE && item.codepoint < CP_DEL) ? 2'd1 : 2'd0;
      end else begin
         cw = (item.glyph_width == 2'd3) ? 2'd1 : item.glyph_width;
      end

      if (text && cw != 2'd0 && column_ff < w) begin
         if (cw == 2'd2) begin
            if ({1'b0, column_ff} + 12'd1 < {1'b0, w}) begin
               wr = 1'b1;
               wd = 1'b1;
            end
         end else begin
            wr = 1'b1;
         end
      end
      if (wr) begin
         column_in = column_ff + (wd ? 11'd2 : 11'd1);
      end

      if (item.line_end) begin
         mode_in    = MODE_TEXT;
         value_in   = 16'd0;
         present_in = 1'b0;
         step_in    = STEP_PLAIN;
         fg_in      = 9'd0;
         bg_in      = 9'd0;
         flags_in   = 4'd0;
         column_in  = 11'd0;
      end

      result.write_cell  = wr;
      result.cell_row    = wr ? item.row : '0;
      result.cell_column = wr ? column_ff[asgr_pkg::CCOL_W-1:0] : '0;
      result.cell_char   = wr ? item.codepoint : '0;
      result.cell_style  = wr ? {flags_ff, bg_ff, fg_ff} : '0;
      result.wide        = wd;
      result.row_error   = rerr;
      result.line_done   = item.line_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_TEXT;
         value_ff   <= 16'd0;
         present_ff <= 1'b0;
         step_ff    <= STEP_PLAIN;
         fg_ff      <= 9'd0;
         bg_ff      <= 9'd0;
         flags_ff   <= 4'd0;
         column_ff  <= 11'd0;
      end else if (advance) begin
         mode_ff    <= mode_in;
         value_ff   <= value_in;
         present_ff <= present_in;
         step_ff    <= step_in;
         fg_ff      <= fg_in;
         bg_ff      <= bg_in;
         flags_ff   <= flags_in;
         column_ff  <= column_in;
      end
   end

endmodule

// ===== rtl/core/ansi_sgr_line_to_cells.sv =====
// channel  dir  handshake             payload
// req      in   req_tvalid/tready     tdata: codepoint, glyph_width, row; tlast: line_end
// rsp      out  rsp_tvalid/tready     tdata: cell fields, wide; tuser: write_cell, row_error;
//                                     tlast: line_done
// csr      in   csr_valid/csr_ready   csr_index, csr_data
//
// One codepoint per cycle unless rsp stalls; items pass the input and rsp registers.
// The parser state update (mode, accumulator multiply by ten, column) is combinational.
// Reset is synchronous; after it the block accepts at once, no clearing pass.
// A stalled rsp holds its register; req keeps flowing until the input register also fills.
// csr writes are always accepted, one per cycle.
`include "ansi_sgr_line_to_cells_macros.svh"

module ansi_sgr_line_to_cells (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // codepoint[20:0], glyph_width[22:21], row[30:23], zero
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // cell_row[7:0], cell_column[17:8], cell_char[38:18],
                                   // cell_style[60:39], wide[61], zero
   output logic [1:0]  rsp_tuser,  // write_cell[0], row_error[1]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [10:0] csr_data
);

   asgr_pkg::cfg_type    cfg;
   asgr_pkg::item_type   s1_item_ff, s1_item_in;
   asgr_pkg::result_type result;
   asgr_pkg::result_type rsp_ff;
   logic                 s1_valid_ff;
   logic                 rsp_valid_ff;
   logic                 advance;
   logic [10:0]          width_eff;

   asgr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   asgr_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg),
      .item    (s1_item_ff),
      .result  (result)
   );

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   always_comb begin
      s1_item_in.codepoint   = req_tdata[20:0];
      s1_item_in.glyph_width = req_tdata[22:21];
      s1_item_in.row         = req_tdata[30:23];
      s1_item_in.line_end    = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_item_ff <= s1_item_in;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.wide, rsp_ff.cell_style, rsp_ff.cell_char,
                        rsp_ff.cell_column, rsp_ff.cell_row};
   assign rsp_tuser  = {rsp_ff.row_error, rsp_ff.write_cell};
   assign rsp_tlast  = rsp_ff.line_done;

   assign width_eff = asgr_pkg::clamp_width(cfg.line_width);

   `ASGR_ASSERT_NOW(a_row_error_no_write, clock, reset,
      rsp_valid_ff && rsp_ff.row_error, !rsp_ff.write_cell)

   `ASGR_ASSERT_NOW(a_wide_fits_line, clock, reset,
      rsp_valid_ff && rsp_ff.write_cell && rsp_ff.wide,
      ({2'b00, rsp_ff.cell_column} + 12'd1) < {1'b0, width_eff})

   `ASGR_ASSERT_NEXT(a_held_item_stays, clock, reset,
      s1_valid_ff && !advance, s1_valid_ff && $stable(s1_item_ff))

endmodule

// ===== bench/ansi_sgr_line_to_cells_test.sv =====
`timescale 1ns / 100ps

module ansi_sgr_line_to_cells_test;
   import asgr_pkg::*;

   typedef enum logic [1:0] {MODE_TEXT, MODE_ESC, MODE_CSI} parse_mode_e;
   typedef enum logic [2:0] {
      STEP_NONE, STEP_FG_SEL, STEP_FG_IDX, STEP_BG_SEL, STEP_BG_IDX
   } color_step_e;

   localparam int SGR_RESET   = 0;
   localparam int SGR_BOLD    = 1;
   localparam int SGR_DIM     = 2;
   localparam int SGR_ITALIC  = 3;
   localparam int SGR_INVERSE = 7;
   localparam int SGR_PALETTE = 5;
   localparam int SGR_FG_EXT  = 38;
   localparam int SGR_BG_EXT  = 48;

   localparam logic [CP_W-1:0] CH_ESC      = 'h1B;
   localparam logic [CP_W-1:0] CH_SPACE    = 'h20;
   localparam logic [CP_W-1:0] CH_ZERO     = 'h30;
   localparam logic [CP_W-1:0] CH_NINE     = 'h39;
   localparam logic [CP_W-1:0] CH_COLON    = 'h3A;
   localparam logic [CP_W-1:0] CH_SEMI     = 'h3B;
   localparam logic [CP_W-1:0] CH_LBRACKET = 'h5B;
   localparam logic [CP_W-1:0] CH_M        = 'h6D;
   localparam logic [CP_W-1:0] CH_DEL      = 'h7F;
   localparam logic [CP_W-1:0] CH_NONASCII = 'h80;

   class cell_write_model;
      logic [LW_W-1:0]  line_width;
      logic [RIU_W-1:0] rows_in_use;
      parse_mode_e      mode;
      logic [15:0]      param_value;
      logic             param_seen;
      color_step_e      step;
      logic [8:0]       fg;
      logic [8:0]       bg;
      logic [3:0]       flags;
      logic [LW_W-1:0]  column_next;
      result_type       expected_cells[$];
      int               mismatches;

      function new();
         line_width  = 80;
         rows_in_use = 24;
         mismatches  = 0;
         clear_line();
      endfunction

      function void clear_line();
         mode        = MODE_TEXT;
         param_value = '0;
         param_seen  = 1'b0;
         step        = STEP_NONE;
         fg          = '0;
         bg          = '0;
         flags       = '0;
         column_next = '0;
      endfunction

      function void set_register(logic idx, logic [10:0] value);
         if (idx == CSR_LINE_WIDTH) line_width = value[LW_W-1:0];
         else rows_in_use = value[RIU_W-1:0];
      endfunction

      function int pending();
         return expected_cells.size();
      endfunction

      function void apply_param();
         int unsigned n;
         n = param_seen ? param_value : 0;
         if (step == STEP_FG_IDX) begin
            fg = 9'(n + 1);
            step = STEP_NONE;
         end else if (step == STEP_BG_IDX) begin
            bg = 9'(n + 1);
            step = STEP_NONE;
         end else if (step == STEP_FG_SEL && n == SGR_PALETTE) begin
            step = STEP_FG_IDX;
         end else if (step == STEP_BG_SEL && n == SGR_PALETTE) begin
            step = STEP_BG_IDX;
         end else begin
            step = STEP_NONE;
            case (n)
               SGR_RESET: begin
                  fg = '0;
                  bg = '0;
                  flags = '0;
               end
               SGR_BOLD:    flags[0] = 1'b1;
               SGR_DIM:     flags[1] = 1'b1;
               SGR_ITALIC:  flags[2] = 1'b1;
               SGR_INVERSE: flags[3] = 1'b1;
               SGR_FG_EXT:  step = STEP_FG_SEL;
               SGR_BG_EXT:  step = STEP_BG_SEL;
               default: ;
            endcase
         end
         param_value = '0;
         param_seen  = 1'b0;
      endfunction

      function void absorb_codepoint(item_type it);
         result_type  r;
         int unsigned lim;
         int unsigned cw;
         int unsigned v;
         bit          text;
         r = '0;
         text = 1'b0;
         lim = (line_width > MAX_COLS) ? MAX_COLS : line_width;
         r.row_error = (it.row >= rows_in_use);
         r.line_done = it.line_end;
         if (!r.row_error) begin
            case (mode)
               MODE_CSI: begin
                  if (it.codepoint >= CH_ZERO && it.codepoint <= CH_NINE) begin
                     v = int'(it.codepoint - CH_ZERO);
                     if (param_seen) v = int'(param_value) * 10 + v;
                     param_value = (v > 65535) ? 16'hFFFF : v[15:0];
                     param_seen = 1'b1;
                  end else begin
                     apply_param();
                     if (it.codepoint == CH_M) begin
                        mode = MODE_TEXT;
                        step = STEP_NONE;
                     end
                  end
               end
               MODE_ESC: begin
                  if (it.codepoint == CH_LBRACKET) begin
                     mode = MODE_CSI;
                     param_value = '0;
                     param_seen = 1'b0;
                     step = STEP_NONE;
                  end else if (it.codepoint != CH_ESC) begin
                     mode = MODE_TEXT;
                     text = 1'b1;
                  end
               end
               default: begin
                  if (it.codepoint == CH_ESC) begin
                     mode = MODE_ESC;
                  end else begin
                     mode = MODE_TEXT;
                     text = 1'b1;
                  end
               end
            endcase
            if (text) begin
               if (it.codepoint < CH_NONASCII)
                  cw = (it.codepoint >= CH_SPACE && it.codepoint < CH_DEL) ? 1 : 0;
               else
                  cw = (it.glyph_width == 2'd3) ? 1 : it.glyph_width;
               if (cw != 0 && column_next < lim && !(cw == 2 && column_next + 1 >= lim)) begin
                  r.write_cell  = 1'b1;
                  r.wide        = (cw == 2);
                  r.cell_row    = it.row;
                  r.cell_column = column_next[CCOL_W-1:0];
                  r.cell_char   = it.codepoint;
                  r.cell_style  = {flags, bg, fg};
                  column_next   = column_next + LW_W'(cw);
               end
            end
         end
         if (it.line_end) clear_line();
         expected_cells.push_back(r);
      endfunction

      function void report(string what, result_type want, result_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("cell mismatch (%s): expected wr=%0d row=%0d col=%0d char=%h style=%h wide=%0d err=%0d done=%0d",
                     what, want.write_cell, want.cell_row, want.cell_column, want.cell_char,
                     want.cell_style, want.wide, want.row_error, want.line_done);
            $display("   actual wr=%0d row=%0d col=%0d char=%h style=%h wide=%0d err=%0d done=%0d",
                     got.write_cell, got.cell_row, got.cell_column, got.cell_char,
                     got.cell_style, got.wide, got.row_error, got.line_done);
         end
      endfunction

      function void check_cell(result_type got);
         result_type want;
         if (expected_cells.size() == 0) begin
            report("no transaction pending", '0, got);
            return;
         end
         want = expected_cells.pop_front();
         if (got.write_cell !== want.write_cell || got.cell_row !== want.cell_row ||
             got.cell_column !== want.cell_column || got.cell_char !== want.cell_char ||
             got.cell_style !== want.cell_style || got.wide !== want.wide ||
             got.row_error !== want.row_error || got.line_done !== want.line_done)
            report("field", want, got);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_LINE_WIDTH;
   logic [10:0] csr_data = '0;

   cell_write_model cells = new();
   item_type        line_q[$];
   bit              tx_fast = 1'b0;
   bit              rx_fast = 1'b0;

   ansi_sgr_line_to_cells dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [GW_W-1:0] rand_gw();
      return GW_W'($urandom_range(0, 3));
   endfunction

   function automatic logic [ROW_W-1:0] pick_row();
      int unsigned rows;
      rows = cells.rows_in_use;
      if (rows == 0 || $urandom_range(0, 99) < 12) return ROW_W'($urandom_range(0, 255));
      return ROW_W'($urandom_range(0, ((rows > 256) ? 256 : rows) - 1));
   endfunction

   function automatic void push_cp(logic [CP_W-1:0] cp, logic [GW_W-1:0] gw);
      item_type it;
      it = '0;
      it.codepoint = cp;
      it.glyph_width = gw;
      line_q.push_back(it);
   endfunction

   function automatic void push_number(int unsigned n);
      int unsigned digits[$];
      do begin
         digits.push_front(n % 10);
         n = n / 10;
      end while (n != 0);
      foreach (digits[i]) push_cp(CH_ZERO + CP_W'(digits[i]), rand_gw());
   endfunction

   function automatic void push_separator();
      logic [CP_W-1:0] cp;
      case ($urandom_range(0, 9))
         0: cp = CH_COLON;
         1: cp = CH_SPACE;
         2: begin
            do cp = CP_W'($urandom);
            while ((cp >= CH_ZERO && cp <= CH_NINE) || cp == CH_M);
         end
         default: cp = CH_SEMI;
      endcase
      push_cp(cp, rand_gw());
   endfunction

   function automatic void push_sgr();
      int nparams;
      nparams = $urandom_range(1, 4);
      push_cp(CH_ESC, rand_gw());
      push_cp(CH_LBRACKET, rand_gw());
      for (int p = 0; p < nparams; p++) begin
         if (p != 0) push_separator();
         case ($urandom_range(0, 9))
            0: push_number(SGR_RESET);
            1: push_number(SGR_BOLD);
            2: push_number(SGR_DIM);
            3: push_number(SGR_ITALIC);
            4: push_number(SGR_INVERSE);
            5, 6: begin
               push_number(($urandom_range(0, 1) != 0) ? SGR_FG_EXT : SGR_BG_EXT);
               push_separator();
               push_number(($urandom_range(0, 9) != 0) ? SGR_PALETTE : $urandom_range(0, 60));
               push_separator();
               push_number(($urandom_range(0, 9) != 0) ? $urandom_range(0, 511)
                                                       : $urandom_range(0, 65535));
            end
            7: push_number($urandom_range(0, 99));
            8: push_number(($urandom_range(0, 1) != 0) ? $urandom_range(65530, 65545) : $urandom);
            default: ;
         endcase
      end
      if ($urandom_range(0, 99) < 85) push_cp(CH_M, rand_gw());
   endfunction

   function automatic void push_token();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         push_cp(CP_W'($urandom_range(CH_SPACE, CH_DEL - 1)), rand_gw());
      end else if (pick < 55) begin
         push_sgr();
      end else if (pick < 67) begin
         push_cp(CP_W'($urandom_range(CH_NONASCII, 'h10FFFF)), 2'd2);
      end else if (pick < 77) begin
         push_cp(CP_W'($urandom_range(CH_NONASCII, 'h1FFFFF)), rand_gw());
      end else if (pick < 84) begin
         push_cp(($urandom_range(0, 3) == 0) ? CH_DEL : CP_W'($urandom_range(0, 31)), rand_gw());
      end else if (pick < 91) begin
         push_cp(CH_ESC, rand_gw());
         if ($urandom_range(0, 3) == 0) push_cp(CH_ESC, rand_gw());
         push_cp(CP_W'($urandom_range(CH_SPACE, CH_DEL)), rand_gw());
      end else begin
         push_cp(CP_W'($urandom), rand_gw());
      end
   endfunction

   task automatic send_item(item_type it);
      int gap;
      gap = tx_fast ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, it.row, it.glyph_width, it.codepoint};
      req_tlast  <= it.line_end;
      do @(posedge clock); while (req_tready !== 1'b1);
      cells.absorb_codepoint(it);
   endtask

   task automatic send_line(logic [ROW_W-1:0] row, bit close);
      item_type it;
      foreach (line_q[i]) begin
         it = line_q[i];
         it.row = ($urandom_range(0, 99) < 4) ? pick_row() : row;
         it.line_end = close && (i == line_q.size() - 1);
         send_item(it);
      end
      line_q.delete();
   endtask

   task automatic wait_drain();
      int n;
      n = 0;
      while (cells.pending() != 0 && n < 5000) begin
         @(posedge clock);
         n++;
      end
   endtask

   task automatic set_geometry(logic [10:0] width, logic [10:0] rows);
      req_tvalid <= 1'b0;
      wait_drain();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_LINE_WIDTH;
      csr_data  <= width;
      do @(posedge clock); while (csr_ready !== 1'b1);
      cells.set_register(CSR_LINE_WIDTH, width);
      csr_index <= CSR_ROWS_IN_USE;
      csr_data  <= rows;
      do @(posedge clock); while (csr_ready !== 1'b1);
      cells.set_register(CSR_ROWS_IN_USE, rows);
      csr_valid <= 1'b0;
   endtask

   initial begin : rsp_sink
      result_type got;
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
            got.write_cell  = rsp_tuser[0];
            got.row_error   = rsp_tuser[1];
            got.line_done   = rsp_tlast;
            got.cell_row    = rsp_tdata[7:0];
            got.cell_column = rsp_tdata[17:8];
            got.cell_char   = rsp_tdata[38:18];
            got.cell_style  = rsp_tdata[60:39];
            got.wide        = rsp_tdata[61];
            cells.check_cell(got);
            if ($urandom_range(0, 99) < 3) rx_fast = !rx_fast;
            stall = rx_fast ? 0 : $urandom_range(0, 19);
            if (stall > 0) rsp_tready <= 1'b0;
         end else if (!rsp_tready) begin
            if (stall <= 1) rsp_tready <= 1'b1;
            else stall--;
         end
      end
   end

   initial begin : stimulus
      int unsigned phase_width[8]  = '{80, 1, 1024, 6, 2047, 12, 3, 40};
      int unsigned phase_rows[8]   = '{24, 1, 256, 200, 511, 0, 128, 24};
      int unsigned phase_budget[8] = '{70, 60, 90, 90, 70, 30, 70, 90};
      int sent;
      int tokens;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      push_cp('h41, rand_gw());
      push_cp(CH_ESC, rand_gw());
      push_cp(CH_LBRACKET, rand_gw());
      push_number(SGR_BOLD);
      push_cp(CH_SEMI, rand_gw());
      push_number(SGR_FG_EXT);
      push_cp(CH_SEMI, rand_gw());
      push_number(SGR_PALETTE);
      push_cp(CH_SEMI, rand_gw());
      push_number(255);
      push_cp(CH_M, rand_gw());
      push_cp('h4E2D, 2'd2);
      push_cp('h0A, rand_gw());
      push_cp('h300, 2'd0);
      push_cp('h1FFFFF, 2'd3);
      push_cp(CH_ESC, rand_gw());
      push_cp('h78, rand_gw());
      send_line(8'd0, 1'b0);
      push_cp('h5A, rand_gw());
      send_line(8'd255, 1'b0);
      push_cp('h7E, rand_gw());
      send_line(8'd23, 1'b1);

      for (int ph = 0; ph < 8; ph++) begin
         if (ph != 0) set_geometry(11'(phase_width[ph]), 11'(phase_rows[ph]));
         sent = 0;
         while (sent < phase_budget[ph]) begin
            tx_fast = ($urandom_range(0, 3) == 0);
            tokens = $urandom_range(1, 12);
            repeat (tokens) push_token();
            sent += line_q.size();
            send_line(pick_row(), $urandom_range(0, 9) != 0);
         end
      end

      req_tvalid <= 1'b0;
      wait_drain();
      repeat (10) @(posedge clock);
      if (cells.mismatches == 0 && cells.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
